// ===== design/pfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfu_pkg;

  // action codes
  localparam logic [3:0] ACT_BCC  = 4'd0;
  localparam logic [3:0] ACT_BRA  = 4'd1;
  localparam logic [3:0] ACT_BSR  = 4'd2;
  localparam logic [3:0] ACT_DBCC = 4'd3;
  localparam logic [3:0] ACT_JMP  = 4'd4;
  localparam logic [3:0] ACT_JSR  = 4'd5;
  localparam logic [3:0] ACT_NOP  = 4'd6;
  localparam logic [3:0] ACT_RTR  = 4'd7;
  localparam logic [3:0] ACT_RTS  = 4'd8;

  // condition codes of opcode bits 11-8
  localparam logic [3:0] CC_T  = 4'd0;
  localparam logic [3:0] CC_F  = 4'd1;
  localparam logic [3:0] CC_HI = 4'd2;
  localparam logic [3:0] CC_LS = 4'd3;
  localparam logic [3:0] CC_CC = 4'd4;
  localparam logic [3:0] CC_CS = 4'd5;
  localparam logic [3:0] CC_NE = 4'd6;
  localparam logic [3:0] CC_EQ = 4'd7;
  localparam logic [3:0] CC_VC = 4'd8;
  localparam logic [3:0] CC_VS = 4'd9;
  localparam logic [3:0] CC_PL = 4'd10;
  localparam logic [3:0] CC_MI = 4'd11;
  localparam logic [3:0] CC_GE = 4'd12;
  localparam logic [3:0] CC_LT = 4'd13;
  localparam logic [3:0] CC_GT = 4'd14;
  localparam logic [3:0] CC_LE = 4'd15;

  // flag bit positions in the x n z v c word
  localparam int FLAG_C = 0;
  localparam int FLAG_V = 1;
  localparam int FLAG_Z = 2;
  localparam int FLAG_N = 3;

  // cycle counts
  localparam logic [4:0] CYC_NONE      = 5'd0;
  localparam logic [4:0] CYC_NOP       = 5'd4;
  localparam logic [4:0] CYC_BCC_BYTE  = 5'd8;
  localparam logic [4:0] CYC_TAKEN     = 5'd10;
  localparam logic [4:0] CYC_BCC_WORD  = 5'd12;
  localparam logic [4:0] CYC_DBCC_TRUE = 5'd12;
  localparam logic [4:0] CYC_DBCC_EXP  = 5'd14;
  localparam logic [4:0] CYC_RTS       = 5'd16;
  localparam logic [4:0] CYC_BSR       = 5'd18;
  localparam logic [4:0] CYC_RTR       = 5'd20;

  // stack adjustments and pc offset
  localparam logic [31:0] SP_PUSH_LONG = 32'd4;
  localparam logic [31:0] SP_POP_RTS   = 32'd4;
  localparam logic [31:0] SP_POP_RTR   = 32'd6;
  localparam logic [31:0] PC_EXT_OFS   = 32'd2;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] opcode;
    logic [15:0] extension_word;
    logic [31:0] instr_addr;
    logic [31:0] return_address;
    logic [31:0] target_address;
    logic        target_is_short;
    logic [4:0]  flags_in;
    logic [15:0] counter_in;
    logic [31:0] stack_pointer_in;
    logic [31:0] popped_long;
    logic [15:0] popped_word;
  } pfu_in_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        pc_written;
    logic [31:0] stack_pointer_out;
    logic        push_write;
    logic [15:0] counter_out;
    logic        counter_write;
    logic [4:0]  flags_out;
    logic        flags_write;
    logic [4:0]  cycles;
  } pfu_out_t;

  // standard condition test
  function automatic logic cond_true(input logic [3:0] cc, input logic [4:0] f);
    logic c;
    logic v;
    logic z;
    logic n;
    logic res;
    c = f[FLAG_C];
    v = f[FLAG_V];
    z = f[FLAG_Z];
    n = f[FLAG_N];
    unique case (cc)
      CC_T:    res = 1'b1;
      CC_F:    res = 1'b0;
      CC_HI:   res = !c && !z;
      CC_LS:   res = c || z;
      CC_CC:   res = !c;
      CC_CS:   res = c;
      CC_NE:   res = !z;
      CC_EQ:   res = z;
      CC_VC:   res = !v;
      CC_VS:   res = v;
      CC_PL:   res = !n;
      CC_MI:   res = n;
      CC_GE:   res = (n == v);
      CC_LT:   res = (n != v);
      CC_GT:   res = !z && (n == v);
      CC_LE:   res = z || (n != v);
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/pfu_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfu_exec (
  input  wire pfu_pkg::pfu_in_t  item,
  output pfu_pkg::pfu_out_t      res
);
  import pfu_pkg::*;

  logic        is_byte;
  logic        cond;
  logic [31:0] disp;
  logic [31:0] btarget;
  logic [31:0] jsr_target;

  // displacement select: dbcc always uses the extension word
  assign is_byte = (item.opcode[7:0] != 8'd0);
  assign disp = (is_byte && (item.action != ACT_DBCC))
              ? {{24{item.opcode[7]}}, item.opcode[7:0]}
              : {{16{item.extension_word[15]}}, item.extension_word};
  assign btarget = item.instr_addr + PC_EXT_OFS + disp;
  assign cond = cond_true(item.opcode[11:8], item.flags_in);
  assign jsr_target = item.target_is_short
                    ? {{16{item.target_address[15]}}, item.target_address[15:0]}
                    : item.target_address;

  // action decode
  always_comb begin
    res.next_pc           = 32'd0;
    res.pc_written        = 1'b0;
    res.stack_pointer_out = item.stack_pointer_in;
    res.push_write        = 1'b0;
    res.counter_out       = item.counter_in - 16'd1;
    res.counter_write     = 1'b0;
    res.flags_out         = item.flags_in;
    res.flags_write       = 1'b0;
    res.cycles            = CYC_NONE;
    unique case (item.action)
      ACT_BCC: begin
        if (cond) begin
          res.next_pc    = btarget;
          res.pc_written = 1'b1;
          res.cycles     = CYC_TAKEN;
        end else begin
          res.cycles = is_byte ? CYC_BCC_BYTE : CYC_BCC_WORD;
        end
      end
      ACT_BRA: begin
        res.next_pc    = btarget;
        res.pc_written = 1'b1;
        res.cycles     = CYC_TAKEN;
      end
      ACT_BSR: begin
        res.stack_pointer_out = item.stack_pointer_in - SP_PUSH_LONG;
        res.push_write        = 1'b1;
        res.next_pc           = btarget;
        res.pc_written        = 1'b1;
        res.cycles            = CYC_BSR;
      end
      ACT_DBCC: begin
        if (cond) begin
          res.cycles = CYC_DBCC_TRUE;
        end else begin
          res.counter_write = 1'b1;
          if (item.counter_in != 16'd0) begin
            res.next_pc    = btarget;
            res.pc_written = 1'b1;
            res.cycles     = CYC_TAKEN;
          end else begin
            res.cycles = CYC_DBCC_EXP;
          end
        end
      end
      ACT_JMP: begin
        res.next_pc    = item.target_address;
        res.pc_written = 1'b1;
      end
      ACT_JSR: begin
        res.stack_pointer_out = item.stack_pointer_in - SP_PUSH_LONG;
        res.push_write        = 1'b1;
        res.next_pc           = jsr_target;
        res.pc_written        = 1'b1;
      end
      ACT_NOP: begin
        res.cycles = CYC_NOP;
      end
      ACT_RTR: begin
        res.flags_out         = item.popped_word[4:0];
        res.flags_write       = 1'b1;
        res.next_pc           = item.popped_long;
        res.pc_written        = 1'b1;
        res.stack_pointer_out = item.stack_pointer_in + SP_POP_RTR;
        res.cycles            = CYC_RTR;
      end
      ACT_RTS: begin
        res.next_pc           = item.popped_long;
        res.pc_written        = 1'b1;
        res.stack_pointer_out = item.stack_pointer_in + SP_POP_RTS;
        res.cycles            = CYC_RTS;
      end
      default: begin
        res.cycles = CYC_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/program_flow_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Program-flow execute unit for a 68000-style core: Bcc, BRA, BSR, DBcc, JMP,
// JSR, NOP, RTR and RTS. Pulse start with an instruction on in_item; busy is
// high through reset and is cleared once reset is released, then stays low, so
// an instruction can be started every clock. The instruction passes through the
// input register and the result register, around one pass of decode, condition
// test and a 32-bit add; the result appears on out_item, marked by a
// one-cycle out_valid strobe; the receiver cannot stall it and must take it
// in that cycle.
// Memory reads and effective address decode are done by the caller.
module program_flow_unit_top (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic start,
  output logic               busy,
  input  wire pfu_pkg::pfu_in_t   in_item,
  output logic               out_valid,
  output pfu_pkg::pfu_out_t  out_item
);
  import pfu_pkg::*;

  logic     busy_r;
  logic     in_valid_r;
  pfu_in_t  in_item_r;
  logic     out_valid_r;
  pfu_out_t out_item_r;
  pfu_out_t exec_res;

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // control: held busy through reset, then one transfer per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      in_valid_r  <= start && !busy_r;
      out_valid_r <= in_valid_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      in_item_r <= in_item;
    end
  end

  pfu_exec u_exec (
    .item (in_item_r),
    .res  (exec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_item_r <= exec_res;
    end
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid)
    else $error("registered instruction produced no result");

  a_push_jumps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.push_write) |-> out_item.pc_written)
    else $error("push without pc change");

  a_rtr_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.flags_write) |->
      (out_item.pc_written && !out_item.push_write))
    else $error("flag restore with wrong pc or stack update");

  a_dbcc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.counter_write) |->
      (!out_item.push_write && !out_item.flags_write))
    else $error("counter write mixed with stack or flag write");
`endif

endmodule

`default_nettype wire
